// File: rtl/exposure_source_selector_macros.svh
// Assertion macros shared by the RTL.
`ifndef EXPOSURE_SOURCE_SELECTOR_MACROS_SVH
`define EXPOSURE_SOURCE_SELECTOR_MACROS_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define ESS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset.
`define ESS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ess_pkg.sv
`default_nettype none

package ess_pkg;

  localparam int MODE_W     = 2;
  localparam int CONF_W     = 17;
  localparam int FRAMES_W   = 8;
  localparam int WINDOW_W   = 32;
  localparam int WP_W       = 32;
  localparam int TIME_W     = 20;
  localparam int AGE_W      = 32;
  localparam int SRC_W      = 2;
  localparam int CAUSE_W    = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int STREAK_BITS_DEF      = 16;
  localparam int WHITE_POINT_BITS_DEF = 32;

  localparam logic [CONF_W-1:0] CONF_ONE         = 17'd65536;
  localparam logic [TIME_W-1:0] DEFAULT_FRAME_US = 20'd16667;

  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GAME   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCAN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd3;

  localparam logic [SRC_W-1:0] SRC_MANUAL = 2'd0;
  localparam logic [SRC_W-1:0] SRC_GAME   = 2'd1;
  localparam logic [SRC_W-1:0] SRC_SCAN   = 2'd2;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE        = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_GAME_FORCED = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_SCAN_FORCED = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_NO_AUTO     = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_MISSING     = 3'd4;

  localparam logic [KIND_W-1:0] KIND_FRESH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REUSED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MANUAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_CONF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PROMOTE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DROP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW   = 3'd4;

  localparam logic [CONF_W-1:0]   RST_MIN_CONF = 17'd32768;
  localparam logic [FRAMES_W-1:0] RST_PROMOTE  = 8'd1;
  localparam logic [FRAMES_W-1:0] RST_DROP     = 8'd1;
  localparam logic [WINDOW_W-1:0] RST_WINDOW   = 32'd1000000;

  typedef struct packed {
    logic              game_present;
    logic              game_valid;
    logic [WP_W-1:0]   game_white_point;
    logic [CONF_W-1:0] game_confidence;
    logic              game_same_frame;
    logic              scan_present;
    logic              scan_valid;
    logic [WP_W-1:0]   scan_white_point;
    logic [CONF_W-1:0] scan_confidence;
    logic              camera_cut;
    logic [TIME_W-1:0] frame_time_us;
  } ess_in_t;

  typedef struct packed {
    logic [SRC_W-1:0]   chosen_source;
    logic [WP_W-1:0]    white_point;
    logic [CONF_W-1:0]  confidence;
    logic               fresh;
    logic               same_frame;
    logic [CAUSE_W-1:0] fallback_cause;
    logic [KIND_W-1:0]  fallback_kind;
  } ess_out_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CONF_W-1:0]   min_confidence;
    logic [FRAMES_W-1:0] promote_frames;
    logic [FRAMES_W-1:0] drop_frames;
    logic [WINDOW_W-1:0] stable_window_us;
  } ess_cfg_t;

endpackage

`default_nettype wire

// File: rtl/ess_cfg_regs.sv
`default_nettype none

module ess_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ess_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ess_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ess_pkg::ess_cfg_t              cfg
);
  import ess_pkg::*;

  ess_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode             <= MODE_MANUAL;
      cfg_r.min_confidence   <= RST_MIN_CONF;
      cfg_r.promote_frames   <= RST_PROMOTE;
      cfg_r.drop_frames      <= RST_DROP;
      cfg_r.stable_window_us <= RST_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MODE:     cfg_r.mode             <= cfg_wdata[MODE_W-1:0];
        CFG_IDX_MIN_CONF: cfg_r.min_confidence   <= cfg_wdata[CONF_W-1:0];
        CFG_IDX_PROMOTE:  cfg_r.promote_frames   <= cfg_wdata[FRAMES_W-1:0];
        CFG_IDX_DROP:     cfg_r.drop_frames      <= cfg_wdata[FRAMES_W-1:0];
        CFG_IDX_WINDOW:   cfg_r.stable_window_us <= cfg_wdata[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/ess_select.sv
`default_nettype none

module ess_select #(
  parameter int STREAK_BITS      = ess_pkg::STREAK_BITS_DEF,
  parameter int WHITE_POINT_BITS = ess_pkg::WHITE_POINT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  ess_pkg::ess_in_t  in_beat,
  input  ess_pkg::ess_cfg_t cfg,
  output ess_pkg::ess_out_t res
);
  import ess_pkg::*;

  localparam int SB     = STREAK_BITS;
  localparam int WP_USE = (WHITE_POINT_BITS < WP_W) ? WHITE_POINT_BITS : WP_W;

  localparam logic signed [SB-1:0] S_MAX     = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN     = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] S_ONE     = {{(SB-1){1'b0}}, 1'b1};
  localparam logic signed [SB-1:0] S_NEG_ONE = {SB{1'b1}};

  function automatic logic signed [SB-1:0] run_update(input logic signed [SB-1:0] s,
                                                       input logic hit);
    logic signed [SB-1:0] r;
    if (hit) begin
      if (s <= $signed({SB{1'b0}})) r = S_ONE;
      else if (s < S_MAX) r = s + S_ONE;
      else r = S_MAX;
    end else begin
      if (s >= $signed({SB{1'b0}})) r = S_NEG_ONE;
      else if (s > S_MIN) r = s - S_ONE;
      else r = S_MIN;
    end
    return r;
  endfunction

  logic [SRC_W-1:0]        active_r;
  logic signed [SB-1:0]    game_streak_r;
  logic signed [SB-1:0]    scan_streak_r;
  logic                    held_valid_r;
  logic [SRC_W-1:0]        held_src_r;
  logic [WP_USE-1:0]       held_wp_r;
  logic [CONF_W-1:0]       held_conf_r;
  logic [AGE_W-1:0]        held_age_r;

  logic [SRC_W-1:0]        active_nxt;
  logic signed [SB-1:0]    game_streak_nxt;
  logic signed [SB-1:0]    scan_streak_nxt;
  logic [AGE_W-1:0]        held_age_nxt;

  logic [CONF_W-1:0]       thr;
  logic [FRAMES_W-1:0]     promote_eff;
  logic [FRAMES_W-1:0]     drop_eff;
  logic signed [SB-1:0]    promote_s;
  logic signed [SB-1:0]    neg_drop_s;
  logic [WP_USE-1:0]       g_wp;
  logic [WP_USE-1:0]       s_wp;
  logic                    g_ok;
  logic                    s_ok;
  logic [SRC_W-1:0]        src;
  logic [CAUSE_W-1:0]      cause;
  logic [WP_USE-1:0]       wp_sel;
  logic [CONF_W-1:0]       conf_sel;
  logic                    held_load;
  logic                    reuse;
  logic [TIME_W-1:0]       dt;
  logic [AGE_W:0]          age_sum;

  always_comb begin
    thr         = (cfg.min_confidence > CONF_ONE) ? CONF_ONE : cfg.min_confidence;
    promote_eff = (cfg.promote_frames == '0) ? RST_PROMOTE : cfg.promote_frames;
    drop_eff    = (cfg.drop_frames == '0) ? RST_DROP : cfg.drop_frames;
    promote_s   = $signed({{(SB-FRAMES_W){1'b0}}, promote_eff});
    neg_drop_s  = $signed({SB{1'b0}}) - $signed({{(SB-FRAMES_W){1'b0}}, drop_eff});

    g_wp = in_beat.game_white_point[WP_USE-1:0];
    s_wp = in_beat.scan_white_point[WP_USE-1:0];
    g_ok = in_beat.game_present && in_beat.game_valid && (g_wp != '0)
           && (in_beat.game_confidence >= thr);
    s_ok = in_beat.scan_present && in_beat.scan_valid && (s_wp != '0)
           && (in_beat.scan_confidence >= thr);

    game_streak_nxt = run_update(game_streak_r, g_ok);
    if (in_beat.camera_cut) scan_streak_nxt = s_ok ? S_ONE : S_NEG_ONE;
    else scan_streak_nxt = run_update(scan_streak_r, s_ok);

    src   = SRC_MANUAL;
    cause = CAUSE_NONE;
    unique case (cfg.mode)
      MODE_MANUAL: src = SRC_MANUAL;
      MODE_GAME: begin
        if (g_ok) src = SRC_GAME;
        else cause = CAUSE_GAME_FORCED;
      end
      MODE_SCAN: begin
        if (s_ok) src = SRC_SCAN;
        else cause = CAUSE_SCAN_FORCED;
      end
      MODE_AUTO: begin
        if (in_beat.camera_cut && g_ok) src = SRC_GAME;
        else if (g_ok && game_streak_nxt >= promote_s) src = SRC_GAME;
        else if (s_ok && scan_streak_nxt >= promote_s) src = SRC_SCAN;
        else if (active_r == SRC_GAME && game_streak_nxt > neg_drop_s) src = SRC_GAME;
        else if (active_r == SRC_SCAN && scan_streak_nxt > neg_drop_s) src = SRC_SCAN;
        else cause = CAUSE_NO_AUTO;
      end
    endcase

    wp_sel   = '0;
    conf_sel = '0;
    res.chosen_source  = SRC_MANUAL;
    res.white_point    = '0;
    res.confidence     = '0;
    res.fresh          = 1'b1;
    res.same_frame     = 1'b0;
    res.fallback_kind  = KIND_MANUAL;

    // resolve: drop a kept source whose measurement is absent
    if (src == SRC_GAME && in_beat.game_present) begin
      wp_sel   = g_wp;
      conf_sel = (in_beat.game_confidence > CONF_ONE) ? CONF_ONE : in_beat.game_confidence;
      res.same_frame = in_beat.game_same_frame;
    end else if (src == SRC_SCAN && in_beat.scan_present) begin
      wp_sel   = s_wp;
      conf_sel = (in_beat.scan_confidence > CONF_ONE) ? CONF_ONE : in_beat.scan_confidence;
    end else if (src != SRC_MANUAL) begin
      src   = SRC_MANUAL;
      cause = CAUSE_MISSING;
    end

    dt = (in_beat.frame_time_us == '0) ? DEFAULT_FRAME_US : in_beat.frame_time_us;
    age_sum = {1'b0, held_age_r} + (AGE_W+1)'(dt);
    held_age_nxt = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];

    held_load = (src != SRC_MANUAL);
    reuse     = !held_load && (cfg.mode != MODE_MANUAL) && held_valid_r
                && (held_age_r <= cfg.stable_window_us);

    if (held_load) begin
      res.chosen_source = src;
      res.white_point   = WP_W'(wp_sel);
      res.confidence    = conf_sel;
      res.fallback_kind = KIND_FRESH;
    end else if (reuse) begin
      res.chosen_source = held_src_r;
      res.white_point   = WP_W'(held_wp_r);
      res.confidence    = held_conf_r;
      res.fresh         = 1'b0;
      res.same_frame    = 1'b0;
      res.fallback_kind = KIND_REUSED;
    end else begin
      res.same_frame    = 1'b0;
    end
    res.fallback_cause = cause;

    active_nxt = src;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= SRC_MANUAL;
      game_streak_r <= '0;
      scan_streak_r <= '0;
      held_valid_r  <= 1'b0;
      held_age_r    <= '0;
    end else if (adv) begin
      active_r      <= active_nxt;
      game_streak_r <= game_streak_nxt;
      scan_streak_r <= scan_streak_nxt;
      if (held_load) begin
        held_valid_r <= 1'b1;
        held_age_r   <= '0;
      end else if (reuse) begin
        held_age_r   <= held_age_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && held_load) begin
      held_src_r  <= src;
      held_wp_r   <= wp_sel;
      held_conf_r <= conf_sel;
    end
  end

endmodule

`default_nettype wire

// File: rtl/exposure_source_selector.sv
// Exposure source selector: one white-point decision per frame beat. A beat is taken
// into an input register, the decision and the streak and last-stable state are worked
// out in one pass, and the result lands in an output register; a new beat is accepted
// every cycle as long as the result side keeps taking beats. Write configuration only
// while no beat is in flight; streaks and active source clear on reset, and the last
// stable decision is marked invalid on reset.
`default_nettype none

`include "exposure_source_selector_macros.svh"

module exposure_source_selector #(
  parameter int STREAK_BITS      = ess_pkg::STREAK_BITS_DEF,
  parameter int WHITE_POINT_BITS = ess_pkg::WHITE_POINT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ess_pkg::ess_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ess_pkg::ess_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [ess_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ess_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ess_pkg::*;

  ess_cfg_t cfg;
  ess_in_t  in_r;
  ess_out_t out_r;
  ess_out_t res;
  logic     in_valid_r;
  logic     out_valid_r;
  logic     in_take;
  logic     adv;
  logic     out_reused;
  logic     out_manual;
  logic     out_stale;
  logic     out_blank;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  ess_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ess_select #(
    .STREAK_BITS      (STREAK_BITS),
    .WHITE_POINT_BITS (WHITE_POINT_BITS)
  ) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_beat (in_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) in_valid_r <= 1'b1;
      else if (adv) in_valid_r <= 1'b0;
      if (adv) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_r <= in_data;
    if (adv) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign out_reused = out_valid_r && (out_r.fallback_kind == KIND_REUSED);
  assign out_manual = out_valid_r && (out_r.fallback_kind == KIND_MANUAL);
  assign out_stale  = !out_r.fresh && !out_r.same_frame;
  assign out_blank  = (out_r.chosen_source == SRC_MANUAL) && (out_r.white_point == '0);

  `ESS_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "advanced beat did not reach output")
  `ESS_ASSERT_IMPLIES(a_reuse_flags, out_reused, out_stale, "reused beat flagged fresh")
  `ESS_ASSERT_IMPLIES(a_manual_zero, out_manual, out_blank, "manual beat carries a source")
  `ESS_ASSERT_IMPLIES(a_conf_clamped, out_valid_r, out_r.confidence <= CONF_ONE, "conf above one")

endmodule

`default_nettype wire
